/* rtl/core/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, defaults and result codes of the sphere merge pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int COORD_PORT_W   = 32;
  localparam int RADIUS_W       = 31;
  localparam int OUT_W          = 32;

  typedef enum logic [1:0] {
    CASE_A_HOLDS_B = 2'd0,
    CASE_B_HOLDS_A = 2'd1,
    CASE_NEW       = 2'd2
  } merge_case_t;

endpackage

/* rtl/core/bsm_front.sv */
// ----------------------------------------------------------------------------
// bsm_front
// Input register, center difference, squares and containment test.
// ----------------------------------------------------------------------------
module bsm_front #(
  parameter int CB = bsm_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     a_x,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     a_y,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     a_z,
  input  logic [bsm_pkg::RADIUS_W-1:0]         a_radius,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     b_x,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     b_y,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]     b_z,
  input  logic [bsm_pkg::RADIUS_W-1:0]         b_radius,
  output logic                                 out_valid,
  output logic [2*CB+3:0]                      dist2,
  output logic                                 contain,
  output logic                                 a_big,
  output logic [2:0][CB-1:0]                   cen,
  output logic [2:0][CB:0]                     mag,
  output logic [2:0]                           neg,
  output logic [bsm_pkg::RADIUS_W-1:0]         ra,
  output logic [bsm_pkg::RADIUS_W-1:0]         rb
);
  import bsm_pkg::*;

  localparam int MW  = CB + 1;
  localparam int D2W = 2 * MW + 2;
  localparam int SQW = 2 * RADIUS_W;
  localparam int CW  = (D2W > SQW) ? D2W : SQW;

  function automatic logic [CB-1:0] fit(input logic [COORD_PORT_W-1:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[CB-1:0];
  endfunction

  // stage 1
  logic                  v1;
  logic [2:0][CB-1:0]    a1, b1;
  logic [RADIUS_W-1:0]   ra1, rb1;
  // stage 2
  logic                  v2;
  logic [2:0][CB-1:0]    a2, b2;
  logic [2:0][MW-1:0]    mag2;
  logic [2:0]            neg2;
  logic [RADIUS_W-1:0]   ra2, rb2, rd2;
  logic                  abig2;
  // stage 3
  logic                  v3;
  logic [2:0][CB-1:0]    a3, b3;
  logic [2:0][MW-1:0]    mag3;
  logic [2:0]            neg3;
  logic [RADIUS_W-1:0]   ra3, rb3;
  logic                  abig3;
  logic [2:0][2*MW-1:0]  sq3;
  logic [SQW-1:0]        rdsq3;

  logic [2:0][MW-1:0]    diff;
  logic [2:0][MW-1:0]    mag_c;
  logic [2:0]            neg_c;
  logic [D2W-1:0]        sum_c;
  logic                  cont_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {b1[i][CB-1], b1[i]} - {a1[i][CB-1], a1[i]};
      neg_c[i] = diff[i][MW-1];
      mag_c[i] = neg_c[i] ? (MW'(0) - diff[i]) : diff[i];
    end
    sum_c  = D2W'(sq3[0]) + D2W'(sq3[1]) + D2W'(sq3[2]);
    cont_c = CW'(sum_c) <= CW'(rdsq3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    a1[0] <= fit(a_x);
    a1[1] <= fit(a_y);
    a1[2] <= fit(a_z);
    b1[0] <= fit(b_x);
    b1[1] <= fit(b_y);
    b1[2] <= fit(b_z);
    ra1   <= a_radius;
    rb1   <= b_radius;

    a2    <= a1;
    b2    <= b1;
    mag2  <= mag_c;
    neg2  <= neg_c;
    ra2   <= ra1;
    rb2   <= rb1;
    abig2 <= ra1 > rb1;
    rd2   <= (ra1 > rb1) ? (ra1 - rb1) : (rb1 - ra1);

    a3    <= a2;
    b3    <= b2;
    mag3  <= mag2;
    neg3  <= neg2;
    ra3   <= ra2;
    rb3   <= rb2;
    abig3 <= abig2;
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= (2*MW)'(mag2[i]) * (2*MW)'(mag2[i]);
    end
    rdsq3 <= SQW'(rd2) * SQW'(rd2);

    dist2   <= sum_c;
    contain <= cont_c;
    a_big   <= abig3;
    cen     <= (cont_c && !abig3) ? b3 : a3;
    mag     <= mag3;
    neg     <= neg3;
    ra      <= ra3;
    rb      <= rb3;
  end

endmodule

/* rtl/core/bsm_sqrt.sv */
// ----------------------------------------------------------------------------
// bsm_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bsm_sqrt #(
  parameter int IN_W   = 68,
  parameter int RES_W  = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RES_W-1:0]  root,
  output logic [SIDE_W-1:0] out_side
);
  import bsm_pkg::*;

  logic              v_q    [RES_W];
  logic [IN_W-1:0]   rem_q  [RES_W];
  logic [RES_W-1:0]  res_q  [RES_W];
  logic [SIDE_W-1:0] side_q [RES_W];

  for (genvar j = 0; j < RES_W; j++) begin : g_stage
    localparam int B = RES_W - 1 - j;
    logic              v_in;
    logic [IN_W-1:0]   rem_in;
    logic [RES_W-1:0]  res_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W-1:0]   trial;
    logic              take;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = radicand;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign res_in  = res_q[j-1];
      assign side_in = side_q[j-1];
    end

    // (res + 2^B)^2 - res^2 = res * 2^(B+1) + 2^(2B)
    assign trial = (IN_W'(res_in) << (B + 1)) | (IN_W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[j]  <= take ? (rem_in - trial) : rem_in;
      res_q[j]  <= take ? (res_in | (RES_W'(1) << B)) : res_in;
      side_q[j] <= side_in;
    end
  end

  assign out_valid = v_q[RES_W-1];
  assign root      = res_q[RES_W-1];
  assign out_side  = side_q[RES_W-1];

endmodule

/* rtl/core/bsm_div.sv */
// ----------------------------------------------------------------------------
// bsm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsm_div #(
  parameter int DEN_W = 33,
  parameter int Q_W   = 33
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quot
);
  import bsm_pkg::*;

  logic             v_q   [Q_W];
  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   part;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = num[DEN_W+Q_W-1:Q_W];
      assign low_in = num[Q_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end

    assign part = {rem_in, low_in[Q_W-1]};
    assign ge   = part >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[j] <= ge ? DEN_W'(part - {1'b0, den_in}) : DEN_W'(part);
      low_q[j] <= low_in << 1;
      quo_q[j] <= {quo_in[Q_W-2:0], ge};
      den_q[j] <= den_in;
    end
  end

  assign out_valid = v_q[Q_W-1];
  assign quot      = quo_q[Q_W-1];

endmodule

/* rtl/core/bounding_sphere_merge.sv */
// ----------------------------------------------------------------------------
// bounding_sphere_merge
// Smallest sphere enclosing two spheres, fully pipelined.
// ----------------------------------------------------------------------------
// Path: the front, the bit-per-stage square root, the radius and product
//   stages, the bit-per-stage dividers over RW = max(32, COORD_BITS+1)
//   quotient bits, then the output register.
// Throughput: one request per cycle; busy is never raised.
// Reset: rst clears the valid bits of every stage; data registers hold junk.
// The receiver cannot stall: done pulses for one cycle with each result.
// ----------------------------------------------------------------------------
module bounding_sphere_merge #(
  parameter int COORD_BITS = bsm_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  a_x,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  a_y,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  a_z,
  input  logic [bsm_pkg::RADIUS_W-1:0]      a_radius,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  b_x,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  b_y,
  input  logic [bsm_pkg::COORD_PORT_W-1:0]  b_z,
  input  logic [bsm_pkg::RADIUS_W-1:0]      b_radius,
  output logic                              done,
  output logic [bsm_pkg::OUT_W-1:0]         out_x,
  output logic [bsm_pkg::OUT_W-1:0]         out_y,
  output logic [bsm_pkg::OUT_W-1:0]         out_z,
  output logic [bsm_pkg::OUT_W-1:0]         out_radius,
  output logic [1:0]                        merge_case
);
  import bsm_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int MW     = CB + 1;                 // |b - a| per axis
  localparam int D2W    = 2 * MW + 2;             // squared distance
  localparam int MAXW   = (MW > OUT_W) ? MW : OUT_W;
  localparam int RW     = MAXW;                   // internal radius, k, offset
  localparam int NUM_W  = MW + RW;                // |d| * k
  localparam int SIDE_W = 3*CB + 3*MW + 3 + 2*RADIUS_W + 2;
  localparam int DLY_W  = 3 + 3*CB + OUT_W + 2;

  // The pipeline never back-pressures.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Front: difference, squares, containment test
  // --------------------------------------------------------------------------
  logic                   fr_valid;
  logic [D2W-1:0]         fr_dist2;
  logic                   fr_contain;
  logic                   fr_abig;
  logic [2:0][CB-1:0]     fr_cen;
  logic [2:0][MW-1:0]     fr_mag;
  logic [2:0]             fr_neg;
  logic [RADIUS_W-1:0]    fr_ra, fr_rb;

  bsm_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .a_radius (a_radius),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .b_radius (b_radius),
    .out_valid(fr_valid),
    .dist2    (fr_dist2),
    .contain  (fr_contain),
    .a_big    (fr_abig),
    .cen      (fr_cen),
    .mag      (fr_mag),
    .neg      (fr_neg),
    .ra       (fr_ra),
    .rb       (fr_rb)
  );

  // --------------------------------------------------------------------------
  // Square root of the squared distance; the rest of the request rides along
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0]      sq_side_in, sq_side_out;
  logic                   sq_valid;
  logic [MW-1:0]          sq_dist;

  logic [2:0][CB-1:0]     sq_cen;
  logic [2:0][MW-1:0]     sq_mag;
  logic [2:0]             sq_neg;
  logic [RADIUS_W-1:0]    sq_ra, sq_rb;
  logic                   sq_contain, sq_abig;

  assign sq_side_in = {fr_cen, fr_mag, fr_neg, fr_ra, fr_rb, fr_contain, fr_abig};
  assign {sq_cen, sq_mag, sq_neg, sq_ra, sq_rb, sq_contain, sq_abig} = sq_side_out;

  bsm_sqrt #(.IN_W(D2W), .RES_W(MW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .radicand (fr_dist2),
    .in_side  (sq_side_in),
    .out_valid(sq_valid),
    .root     (sq_dist),
    .out_side (sq_side_out)
  );

  // --------------------------------------------------------------------------
  // Radius stage: r = (ra + rb + dist) / 2, k = r - ra, saturate out radius; a contained pair keeps the larger radius
  // --------------------------------------------------------------------------
  logic [MAXW:0]          rsum;
  logic [RW-1:0]          r_c, k_c;
  logic                   r_sat;
  logic [OUT_W-1:0]       rad_c;
  merge_case_t            case_c;

  always_comb begin
    rsum  = (MAXW+1)'(sq_ra) + (MAXW+1)'(sq_rb) + (MAXW+1)'(sq_dist);
    r_c   = rsum[MAXW:1];
    k_c   = (r_c >= RW'(sq_ra)) ? (r_c - RW'(sq_ra)) : '0;
    r_sat = (MAXW > OUT_W) && ((r_c >> OUT_W) != '0);
    if (sq_contain) begin
      rad_c = sq_abig ? OUT_W'(sq_ra) : OUT_W'(sq_rb);
    end else begin
      rad_c = r_sat ? '1 : r_c[OUT_W-1:0];
    end
    if (!sq_contain) begin
      case_c = CASE_NEW;
    end else if (sq_abig) begin
      case_c = CASE_A_HOLDS_B;
    end else begin
      case_c = CASE_B_HOLDS_A;
    end
  end

  logic                   vk;
  logic [RW-1:0]          kk;
  logic [MW-1:0]          distk;
  logic [2:0][MW-1:0]     magk;
  logic [2:0]             negk;
  logic [2:0][CB-1:0]     cenk;
  logic [OUT_W-1:0]       radk;
  merge_case_t            casek;

  // Product stage: |d| * k per axis
  logic                   vm;
  logic [2:0][NUM_W-1:0]  prodm;
  logic [MW-1:0]          distm;
  logic [2:0]             negm;
  logic [2:0][CB-1:0]     cenm;
  logic [OUT_W-1:0]       radm;
  merge_case_t            casem;

  always_ff @(posedge clk) begin
    if (rst) begin
      vk <= 1'b0;
      vm <= 1'b0;
    end else begin
      vk <= sq_valid;
      vm <= vk;
    end
  end

  always_ff @(posedge clk) begin
    kk    <= k_c;
    distk <= sq_dist;
    magk  <= sq_mag;
    negk  <= sq_neg;
    cenk  <= sq_cen;
    radk  <= rad_c;
    casek <= case_c;

    for (int i = 0; i < 3; i++) begin
      prodm[i] <= NUM_W'(magk[i]) * NUM_W'(kk);
    end
    distm <= distk;
    negm  <= negk;
    cenm  <= cenk;
    radm  <= radk;
    casem <= casek;
  end

  // --------------------------------------------------------------------------
  // Dividers: offset = |d| * k / dist per axis; sideband follows in a delay line
  // --------------------------------------------------------------------------
  logic [2:0][RW-1:0]     off;
  logic                   dv_valid;

  bsm_div #(.DEN_W(MW), .Q_W(RW)) u_div_x (
    .clk(clk), .rst(rst), .in_valid(vm), .num(prodm[0]), .den(distm),
    .out_valid(dv_valid), .quot(off[0])
  );
  bsm_div #(.DEN_W(MW), .Q_W(RW)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(vm), .num(prodm[1]), .den(distm),
    .out_valid(), .quot(off[1])
  );
  bsm_div #(.DEN_W(MW), .Q_W(RW)) u_div_z (
    .clk(clk), .rst(rst), .in_valid(vm), .num(prodm[2]), .den(distm),
    .out_valid(), .quot(off[2])
  );

  logic [DLY_W-1:0]       dly [RW];

  always_ff @(posedge clk) begin
    dly[0] <= {negm, cenm, radm, casem};
    for (int s = 1; s < RW; s++) begin
      dly[s] <= dly[s-1];
    end
  end

  logic [2:0]             negd;
  logic [2:0][CB-1:0]     cend;
  logic [OUT_W-1:0]       radd;
  logic [1:0]             cased;

  assign {negd, cend, radd, cased} = dly[RW-1];

  // --------------------------------------------------------------------------
  // Output stage: move the center, pick the result, drive the strobe
  // --------------------------------------------------------------------------
  logic [2:0][OUT_W-1:0]  pos_c;

  always_comb begin
    logic signed [63:0] c64;
    logic [OUT_W-1:0]   c32;
    logic [OUT_W-1:0]   o32;
    for (int i = 0; i < 3; i++) begin
      c64 = 64'(signed'(cend[i]));
      c32 = c64[OUT_W-1:0];
      o32 = off[i][OUT_W-1:0];
      if (merge_case_t'(cased) == CASE_NEW) begin
        pos_c[i] = negd[i] ? (c32 - o32) : (c32 + o32);
      end else begin
        pos_c[i] = c32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x      <= pos_c[0];
    out_y      <= pos_c[1];
    out_z      <= pos_c[2];
    out_radius <= radd;
    merge_case <= cased;
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A built sphere always has a nonzero center distance at the dividers.
  assert property (@(posedge clk) disable iff (rst)
    (vm && casem == CASE_NEW) |-> (distm != '0))
    else $error("zero distance reached the dividers on a built sphere");

  // A contained sphere returns an input radius, which fits in 31 bits.
  assert property (@(posedge clk) disable iff (rst)
    (done && merge_case != CASE_NEW) |-> !out_radius[OUT_W-1])
    else $error("containment result carries an out-of-range radius");

  // Every result strobe carries a defined case code.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (merge_case == CASE_A_HOLDS_B || merge_case == CASE_B_HOLDS_A ||
              merge_case == CASE_NEW))
    else $error("undefined merge case on result");

endmodule
